@@ rtl/c_style_unescape_decoder_macros.svh @@
// Assertion macros used by the decoder RTL.
`ifndef C_STYLE_UNESCAPE_DECODER_MACROS_SVH
`define C_STYLE_UNESCAPE_DECODER_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define CSUD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define CSUD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/csud_pkg.sv @@
// Types, character codes and limits shared by the string decoder.
`timescale 1ns / 1ps
`default_nettype none

package csud_pkg;

    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] MAX_LEN   = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 13'd1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_OCT1 = 3'd3,
        PH_OCT2 = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_OK   = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [7:0]         octal_acc;
        logic [COUNT_W-1:0] byte_count;
    } state_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        status_t            status;
        logic [COUNT_W-1:0] consumed;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/csud_in_if.sv @@
// Input channel carrying one raw byte of quoted text per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface csud_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink (input valid, input in_byte, input start_req, output ready);

endinterface

`default_nettype wire

@@ rtl/csud_out_if.sv @@
// Output channel carrying one decoded result per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface csud_out_if;

    logic                          valid;
    logic                          ready;
    logic [7:0]                    out_byte;
    logic [1:0]                    status;
    logic [csud_pkg::COUNT_W-1:0]  consumed;
    logic                          last;

    modport source (output valid, output out_byte, output status, output consumed,
                    output last, input ready);
    modport sink (input valid, input out_byte, input status, input consumed,
                  input last, output ready);

endinterface

`default_nettype wire

@@ rtl/csud_step.sv @@
// Next-state and result logic of the parser for one raw byte.
`timescale 1ns / 1ps
`default_nettype none

module csud_step (
    input  wire logic [7:0]        in_byte,
    input  wire logic              start_req,
    input  wire csud_pkg::state_t  state_cur,
    output csud_pkg::state_t       state_next,
    output logic                   res_valid,
    output csud_pkg::result_t      res
);

    csud_pkg::state_t                  st;
    logic [csud_pkg::COUNT_W-1:0]      cnt_inc;
    logic                              is_oct;
    logic [2:0]                        digit;
    logic                              fail;

    always_comb
    begin
        st = state_cur;
        if (start_req)
        begin
            st.phase      = csud_pkg::PH_WAIT;
            st.octal_acc  = '0;
            st.byte_count = '0;
        end

        cnt_inc = (st.byte_count < csud_pkg::MAX_LEN) ? st.byte_count + csud_pkg::COUNT_ONE
                                                      : st.byte_count;
        is_oct  = (in_byte >= csud_pkg::CH_ZERO) && (in_byte <= csud_pkg::CH_SEVEN);
        digit   = in_byte[2:0];
        fail    = 1'b0;

        state_next   = st;
        res_valid    = 1'b0;
        res.out_byte = '0;
        res.status   = csud_pkg::ST_BYTE;
        res.consumed = '0;
        res.last     = 1'b0;

        unique case (st.phase)
            csud_pkg::PH_WAIT:
            begin
                state_next.byte_count = csud_pkg::COUNT_ONE;
                if (in_byte != csud_pkg::CH_QUOTE)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    state_next.phase = csud_pkg::PH_BODY;
                end
            end
            csud_pkg::PH_BODY:
            begin
                state_next.byte_count = cnt_inc;
                priority if (in_byte == csud_pkg::CH_QUOTE)
                begin
                    state_next.phase = csud_pkg::PH_DONE;
                    res_valid        = 1'b1;
                    res.status       = csud_pkg::ST_OK;
                    res.consumed     = cnt_inc;
                    res.last         = 1'b1;
                end
                else if (in_byte == csud_pkg::CH_BSLASH)
                begin
                    state_next.phase = csud_pkg::PH_ESC;
                end
                else if (in_byte == csud_pkg::CH_NUL)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    res_valid    = 1'b1;
                    res.out_byte = in_byte;
                end
            end
            csud_pkg::PH_ESC:
            begin
                state_next.byte_count = cnt_inc;
                state_next.phase      = csud_pkg::PH_BODY;
                res_valid             = 1'b1;
                unique case (in_byte)
                    csud_pkg::CH_A:      res.out_byte = csud_pkg::CODE_BEL;
                    csud_pkg::CH_B:      res.out_byte = csud_pkg::CODE_BS;
                    csud_pkg::CH_F:      res.out_byte = csud_pkg::CODE_FF;
                    csud_pkg::CH_N:      res.out_byte = csud_pkg::CODE_LF;
                    csud_pkg::CH_R:      res.out_byte = csud_pkg::CODE_CR;
                    csud_pkg::CH_T:      res.out_byte = csud_pkg::CODE_HT;
                    csud_pkg::CH_V:      res.out_byte = csud_pkg::CODE_VT;
                    csud_pkg::CH_BSLASH: res.out_byte = in_byte;
                    csud_pkg::CH_QUOTE:  res.out_byte = in_byte;
                    default:
                    begin
                        res_valid = 1'b0;
                        if (is_oct)
                        begin
                            state_next.octal_acc = {digit[1:0], 6'b0};
                            state_next.phase     = csud_pkg::PH_OCT1;
                        end
                        else
                        begin
                            fail = 1'b1;
                        end
                    end
                endcase
            end
            csud_pkg::PH_OCT1:
            begin
                state_next.byte_count = cnt_inc;
                if (is_oct)
                begin
                    state_next.octal_acc = st.octal_acc | {2'b0, digit, 3'b0};
                    state_next.phase     = csud_pkg::PH_OCT2;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            csud_pkg::PH_OCT2:
            begin
                state_next.byte_count = cnt_inc;
                if (is_oct)
                begin
                    res_valid            = 1'b1;
                    res.out_byte         = st.octal_acc | {5'b0, digit};
                    state_next.octal_acc = '0;
                    state_next.phase     = csud_pkg::PH_BODY;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            csud_pkg::PH_DONE:
            begin
                state_next = st;
            end
            default:
            begin
                state_next = st;
            end
        endcase

        if (fail)
        begin
            state_next.phase = csud_pkg::PH_DONE;
            res_valid        = 1'b1;
            res.out_byte     = '0;
            res.status       = csud_pkg::ST_BAD;
            res.consumed     = '0;
            res.last         = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/c_style_unescape_decoder.sv @@
// Top level of the streaming decoder for double-quoted C-style strings.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one raw byte per transaction on raw and gives at most one result per
// byte on decoded, and it accepts a byte in every cycle unless the input side stalls. An
// accepted byte is held in the input register and passes through the parser logic into the
// result register when the input register advances. The input side stalls only
// when a byte that yields a result meets a full result register that is not being taken.
// Escape introducers, the opening quote, the first two octal digits and bytes after the end
// of a string give no result. A malformed string ends with one result of status 2, after
// which the consumer should drop the bytes already received for that string.
module c_style_unescape_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    csud_in_if.sink     raw,
    csud_out_if.source  decoded
);

`include "c_style_unescape_decoder_macros.svh"

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_start_reg;
    logic               s1_adv;

    csud_pkg::state_t   state_reg;
    csud_pkg::state_t   state_next;

    logic               step_res_valid;
    csud_pkg::result_t  step_res;

    logic               res_valid_reg;
    csud_pkg::result_t  res_reg;

    csud_step u_step (
        .in_byte    (s1_byte_reg),
        .start_req  (s1_start_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    assign s1_adv    = s1_valid_reg && (!step_res_valid || !res_valid_reg || decoded.ready);
    assign raw.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (raw.ready)
        begin
            s1_valid_reg <= raw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            s1_byte_reg  <= raw.in_byte;
            s1_start_reg <= raw.start_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= csud_pkg::PH_WAIT;
            state_reg.octal_acc  <= '0;
            state_reg.byte_count <= '0;
        end
        else if (s1_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv && step_res_valid)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (decoded.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && step_res_valid)
        begin
            res_reg <= step_res;
        end
    end

    assign decoded.valid    = res_valid_reg;
    assign decoded.out_byte = res_reg.out_byte;
    assign decoded.status   = res_reg.status;
    assign decoded.consumed = res_reg.consumed;
    assign decoded.last     = res_reg.last;

    `CSUD_ASSERT(a_last_matches_status, res_valid_reg |-> (res_reg.last == (res_reg.status != csud_pkg::ST_BYTE)), "The last flag disagrees with the result status.")
    `CSUD_ASSERT(a_count_only_on_ok, (res_valid_reg && res_reg.status != csud_pkg::ST_OK) |-> (res_reg.consumed == '0), "A byte count appears on a result that is not an ok end.")
    `CSUD_ASSERT(a_count_saturates, state_reg.byte_count <= csud_pkg::MAX_LEN, "The byte count has passed its limit.")
    `CSUD_ASSERT(a_done_after_last, (s1_adv && step_res_valid && step_res.last) |=> (state_reg.phase == csud_pkg::PH_DONE), "The parser did not finish after the final result.")
    `CSUD_ASSERT(a_silent_when_done, (s1_valid_reg && !s1_start_reg && state_reg.phase == csud_pkg::PH_DONE) |-> !step_res_valid, "A finished string produced a further result.")

endmodule

`default_nettype wire
